FILE: rtl/core/tlqe_pkg.sv
`default_nettype none
package tlqe_pkg;

   // Field widths of the request and response payloads.
   localparam int CoordW = 16;
   localparam int ThickW = 12;
   localparam int ColorW = 8;
   localparam int SlotW  = 16;
   localparam int HalfW  = 13;

   // Widths inside the normal computation.
   localparam int AbsW  = 16;               // |dx|, |dy|
   localparam int SqW   = 2 * AbsW;         // squares
   localparam int SumW  = SqW + 2;          // dx^2 + dy^2
   localparam int TgtW  = SqW + 30;         // a^2 << 30
   localparam int KW    = 15;               // normal magnitude, Q1.14
   localparam int QW    = 52;               // t * s, signed
   localparam int PW    = 70;               // t^2 * s, signed headroom
   localparam int ProdW = KW + HalfW;       // |n| * H
   localparam int OffW  = 14;               // signed offset, Q.4

   // Register indexes of the configuration port.
   localparam logic [1:0] RegGlowMargin = 2'd0;
   localparam logic [1:0] RegGlowAlpha  = 2'd1;
   localparam logic [1:0] RegCoreAlpha  = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [11:0] GlowMarginReset = 12'd224;
   localparam logic [7:0]  GlowAlphaReset  = 8'd60;
   localparam logic [7:0]  CoreAlphaReset  = 8'd255;

   // One segment as it travels down the pipeline.
   typedef struct packed {
      logic signed [CoordW-1:0] sx;
      logic signed [CoordW-1:0] sy;
      logic signed [CoordW-1:0] ex;
      logic signed [CoordW-1:0] ey;
      logic [ThickW-1:0]        thick;
      logic [HalfW-1:0]         glow_h;
      logic [ColorW-1:0]        red;
      logic [ColorW-1:0]        green;
      logic [ColorW-1:0]        blue;
      logic [SlotW-1:0]         slot;
      logic                     neg_x;
      logic                     neg_y;
      logic                     zero;
      logic [AbsW-1:0]          adx;
      logic [AbsW-1:0]          ady;
      logic [SqW-1:0]           sq_dx;
      logic [SqW-1:0]           sq_dy;
      logic [SumW-1:0]          s;
      logic [TgtW-1:0]          tgt_x;
      logic [TgtW-1:0]          tgt_y;
      logic signed [PW-1:0]     p_x;
      logic signed [PW-1:0]     p_y;
      logic signed [QW-1:0]     q_x;
      logic signed [QW-1:0]     q_y;
      logic [KW-1:0]            k_x;
      logic [KW-1:0]            k_y;
      logic [ProdW-1:0]         m_gx;
      logic [ProdW-1:0]         m_gy;
      logic [ProdW-1:0]         m_cx;
      logic [ProdW-1:0]         m_cy;
      logic signed [OffW-1:0]   o_gx;
      logic signed [OffW-1:0]   o_gy;
      logic signed [OffW-1:0]   o_cx;
      logic signed [OffW-1:0]   o_cy;
   } pipe_type;

endpackage
`default_nettype wire

FILE: rtl/core/tlqe_if.sv
`default_nettype none
// Segment request channel.
interface tlqe_req_if;
   import tlqe_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [CoordW-1:0] start_x;
   logic signed [CoordW-1:0] start_y;
   logic signed [CoordW-1:0] end_x;
   logic signed [CoordW-1:0] end_y;
   logic [ThickW-1:0]        thickness;
   logic [ColorW-1:0]        red;
   logic [ColorW-1:0]        green;
   logic [ColorW-1:0]        blue;
   logic [SlotW-1:0]         beam_slot;
   modport source (output valid, start_x, start_y, end_x, end_y, thickness,
                   red, green, blue, beam_slot, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, thickness,
                 red, green, blue, beam_slot, output ready);
endinterface

// Vertex response channel.
interface tlqe_rsp_if;
   import tlqe_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [CoordW-1:0] vertex_x;
   logic signed [CoordW-1:0] vertex_y;
   logic [ColorW-1:0]        out_red;
   logic [ColorW-1:0]        out_green;
   logic [ColorW-1:0]        out_blue;
   logic [ColorW-1:0]        alpha;
   logic                     layer;
   logic [1:0]               corner;
   logic [SlotW-1:0]         slot_out;
   logic                     last;
   modport source (output valid, vertex_x, vertex_y, out_red, out_green, out_blue,
                   alpha, layer, corner, slot_out, last, input ready);
   modport sink (input valid, vertex_x, vertex_y, out_red, out_green, out_blue,
                 alpha, layer, corner, slot_out, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tlqe_norm_step.sv
`default_nettype none
// One bit of the normal magnitude search for both components. Keeps
// P = t^2 * s and Q = t * s with t = 2k - 1, and tries k + 2^BIT.
module tlqe_norm_step #(
   parameter int BIT = 0
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  tlqe_pkg::pipe_type   in_data,
   output logic                 out_valid,
   input  wire                  out_ready,
   output tlqe_pkg::pipe_type   out_data
);
   import tlqe_pkg::*;

   logic                 valid_ff;
   pipe_type             data_ff;
   pipe_type             data_in;
   logic                 advance;
   logic signed [PW-1:0] s_ext;
   logic signed [QW-1:0] s_extq;
   logic signed [PW-1:0] trial_x;
   logic signed [PW-1:0] trial_y;
   logic signed [PW-1:0] tgt_x_ext;
   logic signed [PW-1:0] tgt_y_ext;

   assign advance   = !valid_ff || out_ready;
   assign in_ready  = advance;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Trial square for the raised k and the compare against the target.
   always_comb begin
      s_ext     = PW'(in_data.s);
      s_extq    = QW'(in_data.s);
      tgt_x_ext = PW'(in_data.tgt_x);
      tgt_y_ext = PW'(in_data.tgt_y);
      trial_x   = in_data.p_x + (PW'(in_data.q_x) <<< (BIT + 2))
                  + (s_ext <<< (2 * BIT + 2));
      trial_y   = in_data.p_y + (PW'(in_data.q_y) <<< (BIT + 2))
                  + (s_ext <<< (2 * BIT + 2));
      data_in   = in_data;
      if (trial_x <= tgt_x_ext) begin
         data_in.p_x      = trial_x;
         data_in.q_x      = in_data.q_x + (s_extq <<< (BIT + 1));
         data_in.k_x[BIT] = 1'b1;
      end
      if (trial_y <= tgt_y_ext) begin
         data_in.p_y      = trial_y;
         data_in.q_y      = in_data.q_y + (s_extq <<< (BIT + 1));
         data_in.k_y[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/thick_line_quad_expand_core.sv
`default_nettype none
// Thick line quad expander.
// A request on req_ch carries one segment: start and end points in signed
// Q12.4, a Q8.4 thickness, an RGB color and a beam slot. For each request the
// block sends eight vertices on rsp_ch: the glow quad (half width
// (thickness + glow_margin) / 2) and then the core quad (half width
// thickness / 2), each as start+n, start-n, end+n, end-n; last marks the
// eighth. Alpha comes from glow_alpha or core_alpha.
// The csr_ port writes glow_margin, glow_alpha and core_alpha; write it only
// while no request is in flight.
// The unit normal is found one bit per pipeline stage (15 stages), between
// an input, square, setup stage and an offset multiply and rounding stage.
// The single response port carries eight vertices per request and so sets the
// request rate; the pipeline itself takes one per cycle when not stalled.
// Reset clears all valid bits and loads the register defaults. When the
// receiver stalls, the output register holds its vertex and the pipeline
// fills and then deasserts req_ch.ready; nothing is dropped or repeated.
module thick_line_quad_expand_core (
   input  wire               clock,
   input  wire               reset,
   tlqe_req_if.sink          req_ch,
   tlqe_rsp_if.source        rsp_ch,
   input  wire               csr_we,
   input  wire  [1:0]        csr_index,
   input  wire  [11:0]       csr_wdata
);
   import tlqe_pkg::*;

   localparam int NSteps = KW;

   // Configuration registers.
   logic [11:0] glow_margin_ff;
   logic [7:0]  glow_alpha_ff;
   logic [7:0]  core_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         glow_margin_ff <= GlowMarginReset;
         glow_alpha_ff  <= GlowAlphaReset;
         core_alpha_ff  <= CoreAlphaReset;
      end else if (csr_we) begin
         unique case (csr_index)
            RegGlowMargin: glow_margin_ff <= csr_wdata;
            RegGlowAlpha:  glow_alpha_ff  <= csr_wdata[7:0];
            RegCoreAlpha:  core_alpha_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Pipeline stage registers.
   logic     in_v_ff, sq_v_ff, init_v_ff, off_v_ff, rnd_v_ff;
   pipe_type in_d_ff, sq_d_ff, init_d_ff, off_d_ff, rnd_d_ff;
   pipe_type in_d_in, sq_d_in, init_d_in, off_d_in, rnd_d_in;
   logic     in_adv, sq_adv, init_adv, off_adv, rnd_adv;

   logic     step_v [NSteps+1];
   logic     step_r [NSteps+1];
   pipe_type step_d [NSteps+1];

   // Output side: a held segment, its vertex counter and the output register.
   logic       hold_v_ff;
   pipe_type   hold_d_ff;
   logic [2:0] cnt_ff;
   logic       out_v_ff;
   logic       out_adv;
   logic       emit;
   logic       hold_take;

   // Input stage: endpoint differences, their magnitudes and the signs.
   logic signed [CoordW:0] dx, dy;
   always_comb begin
      dx = {req_ch.end_x[CoordW-1], req_ch.end_x}
           - {req_ch.start_x[CoordW-1], req_ch.start_x};
      dy = {req_ch.end_y[CoordW-1], req_ch.end_y}
           - {req_ch.start_y[CoordW-1], req_ch.start_y};
      in_d_in        = '0;
      in_d_in.sx     = req_ch.start_x;
      in_d_in.sy     = req_ch.start_y;
      in_d_in.ex     = req_ch.end_x;
      in_d_in.ey     = req_ch.end_y;
      in_d_in.thick  = req_ch.thickness;
      in_d_in.glow_h = HalfW'(req_ch.thickness) + HalfW'(glow_margin_ff);
      in_d_in.red    = req_ch.red;
      in_d_in.green  = req_ch.green;
      in_d_in.blue   = req_ch.blue;
      in_d_in.slot   = req_ch.beam_slot;
      in_d_in.neg_x  = (dy > 0);
      in_d_in.neg_y  = dx[CoordW];
      in_d_in.zero   = (dx == '0) && (dy == '0);
      in_d_in.adx    = dx[CoordW] ? AbsW'(-dx) : AbsW'(dx);
      in_d_in.ady    = dy[CoordW] ? AbsW'(-dy) : AbsW'(dy);
   end

   // Square stage.
   always_comb begin
      sq_d_in       = in_d_ff;
      sq_d_in.sq_dx = in_d_ff.adx * in_d_ff.adx;
      sq_d_in.sq_dy = in_d_ff.ady * in_d_ff.ady;
   end

   // Setup stage: s, search targets and the search state for k = 0.
   always_comb begin
      init_d_in       = sq_d_ff;
      init_d_in.s     = SumW'(sq_d_ff.sq_dx) + SumW'(sq_d_ff.sq_dy);
      init_d_in.tgt_x = {sq_d_ff.sq_dy, 30'b0};
      init_d_in.tgt_y = {sq_d_ff.sq_dx, 30'b0};
      init_d_in.p_x   = PW'(init_d_in.s);
      init_d_in.p_y   = PW'(init_d_in.s);
      init_d_in.q_x   = -QW'(init_d_in.s);
      init_d_in.q_y   = -QW'(init_d_in.s);
      init_d_in.k_x   = '0;
      init_d_in.k_y   = '0;
   end

   // Offset multiply stage: |n| times the doubled half widths.
   logic [KW-1:0] mag_x, mag_y;
   always_comb begin
      mag_x         = step_d[NSteps].zero ? '0 : step_d[NSteps].k_x;
      mag_y         = step_d[NSteps].zero ? '0 : step_d[NSteps].k_y;
      off_d_in      = step_d[NSteps];
      off_d_in.m_gx = ProdW'(mag_x) * ProdW'(step_d[NSteps].glow_h);
      off_d_in.m_gy = ProdW'(mag_y) * ProdW'(step_d[NSteps].glow_h);
      off_d_in.m_cx = ProdW'(mag_x) * ProdW'(step_d[NSteps].thick);
      off_d_in.m_cy = ProdW'(mag_y) * ProdW'(step_d[NSteps].thick);
   end

   // Rounding stage: round to Q.4 by magnitude and apply the normal's sign.
   function automatic logic signed [OffW-1:0] round_off(input logic [ProdW-1:0] m,
                                                        input logic neg);
      logic [ProdW:0]   sum;
      logic [OffW-1:0]  mag;
      sum = {1'b0, m} + (ProdW+1)'(16384);
      mag = OffW'(sum >> 15);
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   always_comb begin
      rnd_d_in      = off_d_ff;
      rnd_d_in.o_gx = round_off(off_d_ff.m_gx, off_d_ff.neg_x);
      rnd_d_in.o_gy = round_off(off_d_ff.m_gy, off_d_ff.neg_y);
      rnd_d_in.o_cx = round_off(off_d_ff.m_cx, off_d_ff.neg_x);
      rnd_d_in.o_cy = round_off(off_d_ff.m_cy, off_d_ff.neg_y);
   end

   // Back-pressure chain.
   assign out_adv   = !out_v_ff || rsp_ch.ready;
   assign emit      = hold_v_ff && out_adv;
   assign hold_take = !hold_v_ff || (emit && (cnt_ff == 3'd7));
   assign rnd_adv   = !rnd_v_ff || hold_take;
   assign off_adv   = !off_v_ff || rnd_adv;
   assign step_r[NSteps] = off_adv;
   assign init_adv  = !init_v_ff || step_r[0];
   assign sq_adv    = !sq_v_ff || init_adv;
   assign in_adv    = !in_v_ff || sq_adv;
   assign req_ch.ready = in_adv;

   assign step_v[0] = init_v_ff;
   assign step_d[0] = init_d_ff;

   // Normal search, most significant bit first.
   for (genvar i = 0; i < NSteps; i++) begin : g_step
      tlqe_norm_step #(.BIT(NSteps - 1 - i)) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (step_v[i]),
         .in_ready  (step_r[i]),
         .in_data   (step_d[i]),
         .out_valid (step_v[i+1]),
         .out_ready (step_r[i+1]),
         .out_data  (step_d[i+1])
      );
   end

   // Stage registers with valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff   <= 1'b0;
         sq_v_ff   <= 1'b0;
         init_v_ff <= 1'b0;
         off_v_ff  <= 1'b0;
         rnd_v_ff  <= 1'b0;
      end else begin
         if (in_adv)   in_v_ff   <= req_ch.valid;
         if (sq_adv)   sq_v_ff   <= in_v_ff;
         if (init_adv) init_v_ff <= sq_v_ff;
         if (off_adv)  off_v_ff  <= step_v[NSteps];
         if (rnd_adv)  rnd_v_ff  <= off_v_ff;
      end
      if (in_adv && req_ch.valid)        in_d_ff   <= in_d_in;
      if (sq_adv && in_v_ff)             sq_d_ff   <= sq_d_in;
      if (init_adv && sq_v_ff)           init_d_ff <= init_d_in;
      if (off_adv && step_v[NSteps])     off_d_ff  <= off_d_in;
      if (rnd_adv && off_v_ff)           rnd_d_ff  <= rnd_d_in;
   end

   // Vertex for the current count: endpoint plus or minus the offset.
   function automatic logic signed [CoordW-1:0] sat_add(
      input logic signed [CoordW-1:0] p,
      input logic signed [OffW-1:0]   o,
      input logic                     sub);
      logic signed [CoordW+1:0] sum;
      sum = sub ? ((CoordW+2)'(p) - (CoordW+2)'(o))
                : ((CoordW+2)'(p) + (CoordW+2)'(o));
      if (sum > (CoordW+2)'(32767))       return 16'sh7fff;
      else if (sum < -(CoordW+2)'(32768)) return 16'sh8000;
      else                                return sum[CoordW-1:0];
   endfunction

   logic                     v_layer;
   logic [1:0]               v_corner;
   logic signed [CoordW-1:0] v_px, v_py;
   logic signed [OffW-1:0]   v_ox, v_oy;
   always_comb begin
      v_layer  = cnt_ff[2];
      v_corner = cnt_ff[1:0];
      v_px     = v_corner[1] ? hold_d_ff.ex : hold_d_ff.sx;
      v_py     = v_corner[1] ? hold_d_ff.ey : hold_d_ff.sy;
      v_ox     = v_layer ? hold_d_ff.o_cx : hold_d_ff.o_gx;
      v_oy     = v_layer ? hold_d_ff.o_cy : hold_d_ff.o_gy;
   end

   // Serializer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         cnt_ff    <= '0;
         out_v_ff  <= 1'b0;
      end else begin
         if (emit) cnt_ff <= cnt_ff + 3'd1;
         if (hold_take) hold_v_ff <= rnd_v_ff;
         if (out_adv) out_v_ff <= hold_v_ff;
      end
      if (hold_take && rnd_v_ff) hold_d_ff <= rnd_d_ff;
      if (emit) begin
         rsp_ch.vertex_x  <= sat_add(v_px, v_ox, v_corner[0]);
         rsp_ch.vertex_y  <= sat_add(v_py, v_oy, v_corner[0]);
         rsp_ch.out_red   <= hold_d_ff.red;
         rsp_ch.out_green <= hold_d_ff.green;
         rsp_ch.out_blue  <= hold_d_ff.blue;
         rsp_ch.alpha     <= v_layer ? core_alpha_ff : glow_alpha_ff;
         rsp_ch.layer     <= v_layer;
         rsp_ch.corner    <= v_corner;
         rsp_ch.slot_out  <= hold_d_ff.slot;
         rsp_ch.last      <= (cnt_ff == 3'd7);
      end
   end

   assign rsp_ch.valid = out_v_ff;

endmodule
`default_nettype wire
